### sv/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; expects clk and arst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define EWT_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("edge table check failed");
`define EWT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("edge table check failed");
`endif

### sv/ewt_pkg.sv
// Types and codes of the weighted edge table.
// No dependencies.
package ewt_pkg;
	localparam int VW = 5;
	localparam int FW = 4;
	localparam int WW = 32;
	localparam int MAX_VERTICES = 16;

	typedef struct packed {
		logic [VW-1:0]        src;
		logic [VW-1:0]        dst;
		logic signed [WW-1:0] weight;
	} entry_t;

	localparam logic [3:0] MODE_FILL     = 4'd0;
	localparam logic [3:0] MODE_CONNECT  = 4'd1;
	localparam logic [3:0] MODE_CONN_DEF = 4'd2;
	localparam logic [3:0] MODE_REMOVE   = 4'd3;
	localparam logic [3:0] MODE_EXISTS   = 4'd4;
	localparam logic [3:0] MODE_SET      = 4'd5;
	localparam logic [3:0] MODE_SET_DEF  = 4'd6;
	localparam logic [3:0] MODE_MIN_IN   = 4'd7;
	localparam logic [3:0] MODE_RM_IN    = 4'd8;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_RANGE = 2'd1;
	localparam logic [1:0] STAT_NONE  = 2'd2;
	localparam logic [1:0] STAT_FULL  = 2'd3;

	localparam logic [1:0] REG_VCOUNT  = 2'd0;
	localparam logic [1:0] REG_DEFW    = 2'd1;
	localparam logic [1:0] REG_CEILING = 2'd2;
endpackage

### sv/ewt_cell.sv
// One cell of the edge chain: holds one entry, takes its neighbor's or the write data on shift.
// Depends on ewt_pkg.
module ewt_cell (
	input  logic            clk,
	input  logic            shift_en,
	input  logic            wr_en,
	input  ewt_pkg::entry_t wr_data,
	input  ewt_pkg::entry_t nbr_data,
	output ewt_pkg::entry_t data
);
	ewt_pkg::entry_t data_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			data_q <= wr_en ? wr_data : nbr_data;
		end
	end

	assign data = data_q;
endmodule

### sv/weighted_edge_table_core.sv
// Weighted edge table: an ordered list of directed weighted edges held in a chain
// of cells. Every request that passes its index check runs one full turn of the
// chain, with the list streaming out of the front cell and written back behind it.
// The finish state then registers the result and raises out_valid, and the next
// request can transfer in the cycle after the result transfer. A request that fails
// its index check skips the chain turn and goes from idle straight to the finish
// state. One request is in work at a time. Depends on ewt_pkg and ewt_cell.
module weighted_edge_table_core #(
	parameter int EDGE_SLOTS   = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [1:0]                          cfg_index,
	input  logic [31:0]                         cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [3:0]                          mode,
	input  logic [ewt_pkg::FW-1:0]              src_vertex,
	input  logic [ewt_pkg::FW-1:0]              dst_vertex,
	input  logic signed [31:0]                  edge_weight_in,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [1:0]                          status,
	output logic                                found,
	output logic [ewt_pkg::FW-1:0]              min_source,
	output logic signed [31:0]                  min_weight,
	output logic [$clog2(EDGE_SLOTS+1)-1:0]     edge_total
);
	localparam int AW = $clog2(EDGE_SLOTS);
	localparam int CW = $clog2(EDGE_SLOTS+1);
	localparam int VW = ewt_pkg::VW;

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FIN, ST_OUT} state_t;
	state_t state_q;

	logic [4:0]         vcount_q;
	logic signed [31:0] defw_q, ceil_q;
	logic [CW-1:0]      count_q, cnt_q, push_q, skip_q;
	logic [3:0]         mode_q;
	logic [VW-1:0]      s_q, d_q, n_q, gi_q, gj_q;
	logic               gdone_q, seen_q, err_q;
	logic signed [31:0] w_q, best_q;
	logic [VW-1:0]      bsrc_q;

	ewt_pkg::entry_t chain [EDGE_SLOTS];
	ewt_pkg::entry_t head, push_val, zero_entry;
	logic            push, run;
	logic [AW-1:0]   wpos;

	// vertex count clamp and index checks
	logic [VW-1:0] n_acc;
	logic          s_ok, d_ok, pair_ok, bad_req;
	always_comb begin
		n_acc = (vcount_q > VW'(ewt_pkg::MAX_VERTICES)) ?
			VW'(ewt_pkg::MAX_VERTICES) : vcount_q;
		s_ok = {1'b0, src_vertex} < n_acc;
		d_ok = {1'b0, dst_vertex} < n_acc;
		pair_ok = s_ok && d_ok;
		case (mode)
			ewt_pkg::MODE_FILL: bad_req = 1'b0;
			ewt_pkg::MODE_CONNECT, ewt_pkg::MODE_CONN_DEF, ewt_pkg::MODE_REMOVE,
			ewt_pkg::MODE_EXISTS, ewt_pkg::MODE_SET, ewt_pkg::MODE_SET_DEF:
				bad_req = !pair_ok;
			ewt_pkg::MODE_MIN_IN, ewt_pkg::MODE_RM_IN: bad_req = !d_ok;
			default: bad_req = 1'b1;
		endcase
	end

	// fill pair generator
	logic [VW-1:0] ni, nj, ni2, nj2;
	logic          ndone;
	always_comb begin
		nj = gj_q + 1'b1;
		ni = gi_q;
		if (nj == n_q) begin
			nj = '0;
			ni = gi_q + 1'b1;
		end
		ni2 = ni;
		nj2 = nj;
		if (nj == ni) begin
			nj2 = nj + 1'b1;
			if (nj2 == n_q) begin
				nj2 = '0;
				ni2 = ni + 1'b1;
			end
		end
		ndone = (ni2 == n_q);
	end

	assign run  = (state_q == ST_RUN);
	assign head = chain[0];
	assign zero_entry = '0;
	assign wpos = AW'(CW'(EDGE_SLOTS - 1) - skip_q);

	logic in_list, match, dmatch;
	always_comb begin
		in_list  = cnt_q < count_q;
		match    = in_list && head.src == s_q && head.dst == d_q;
		dmatch   = in_list && head.dst == d_q;
		push     = in_list;
		push_val = head;
		case (mode_q)
			ewt_pkg::MODE_FILL: begin
				push = !gdone_q;
				push_val.src = gi_q;
				push_val.dst = gj_q;
				push_val.weight = defw_q;
			end
			ewt_pkg::MODE_CONNECT, ewt_pkg::MODE_CONN_DEF: begin
				if (match && !seen_q && mode_q == ewt_pkg::MODE_CONNECT && w_q < head.weight)
					push_val.weight = w_q;
				if (cnt_q == count_q && !seen_q && s_q != d_q) begin
					push = 1'b1;
					push_val.src = s_q;
					push_val.dst = d_q;
					push_val.weight = (mode_q == ewt_pkg::MODE_CONNECT) ? w_q : defw_q;
				end
			end
			ewt_pkg::MODE_REMOVE: if (match && !seen_q) push = 1'b0;
			ewt_pkg::MODE_SET: if (match && !seen_q) push_val.weight = w_q;
			ewt_pkg::MODE_SET_DEF: if (match && !seen_q) push_val.weight = defw_q;
			ewt_pkg::MODE_RM_IN: if (dmatch) push = 1'b0;
			default: ;
		endcase
	end

	for (genvar k = 0; k < EDGE_SLOTS; k++) begin : g_cell
		ewt_pkg::entry_t nbr;
		if (k == EDGE_SLOTS - 1) begin : g_last
			assign nbr = zero_entry;
		end else begin : g_mid
			assign nbr = chain[k+1];
		end
		ewt_cell u_cell (
			.clk      (clk),
			.shift_en (run),
			.wr_en    (push && wpos == AW'(k)),
			.wr_data  (push_val),
			.nbr_data (nbr),
			.data     (chain[k])
		);
	end

	assign in_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			vcount_q   <= 5'd16;
			defw_q     <= '0;
			ceil_q     <= 32'sd25599744;
			count_q    <= '0;
			out_valid  <= 1'b0;
			mode_q     <= '0;
			s_q        <= '0;
			d_q        <= '0;
			w_q        <= '0;
			n_q        <= '0;
			err_q      <= 1'b0;
			best_q     <= '0;
			bsrc_q     <= '0;
			seen_q     <= 1'b0;
			cnt_q      <= '0;
			push_q     <= '0;
			skip_q     <= '0;
			gi_q       <= '0;
			gj_q       <= '0;
			gdone_q    <= 1'b0;
			status     <= '0;
			found      <= 1'b0;
			min_source <= '0;
			min_weight <= '0;
			edge_total <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					ewt_pkg::REG_VCOUNT:  vcount_q <= cfg_data[4:0];
					ewt_pkg::REG_DEFW:    defw_q   <= cfg_data;
					ewt_pkg::REG_CEILING: ceil_q   <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						mode_q  <= mode;
						s_q     <= {1'b0, src_vertex};
						d_q     <= {1'b0, dst_vertex};
						w_q     <= edge_weight_in;
						n_q     <= n_acc;
						err_q   <= bad_req;
						best_q  <= ceil_q;
						bsrc_q  <= '0;
						seen_q  <= 1'b0;
						cnt_q   <= '0;
						push_q  <= '0;
						skip_q  <= '0;
						gi_q    <= '0;
						gj_q    <= VW'(1);
						gdone_q <= (n_acc < VW'(2));
						state_q <= bad_req ? ST_FIN : ST_RUN;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (push) push_q <= push_q + 1'b1;
					else skip_q <= skip_q + 1'b1;
					if (mode_q == ewt_pkg::MODE_FILL && !gdone_q) begin
						gi_q <= ni2;
						gj_q <= nj2;
						gdone_q <= ndone;
					end
					if (mode_q == ewt_pkg::MODE_MIN_IN) begin
						if (dmatch && head.weight < best_q) begin
							best_q <= head.weight;
							bsrc_q <= head.src;
							seen_q <= 1'b1;
						end
					end else if (match) begin
						seen_q <= 1'b1;
					end
					if (cnt_q == CW'(EDGE_SLOTS - 1)) state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!err_q) count_q <= push_q;
					edge_total <= err_q ? count_q : push_q;
					found      <= 1'b0;
					min_source <= '0;
					min_weight <= '0;
					status     <= ewt_pkg::STAT_OK;
					if (err_q) begin
						status <= ewt_pkg::STAT_RANGE;
					end else begin
						case (mode_q)
							ewt_pkg::MODE_FILL:
								if (!gdone_q) status <= ewt_pkg::STAT_FULL;
							ewt_pkg::MODE_CONNECT, ewt_pkg::MODE_CONN_DEF: begin
								found <= seen_q;
								if (!seen_q && s_q != d_q && count_q == CW'(EDGE_SLOTS))
									status <= ewt_pkg::STAT_FULL;
							end
							ewt_pkg::MODE_REMOVE, ewt_pkg::MODE_SET, ewt_pkg::MODE_SET_DEF: begin
								found <= seen_q;
								if (!seen_q) status <= ewt_pkg::STAT_NONE;
							end
							ewt_pkg::MODE_EXISTS: found <= seen_q;
							ewt_pkg::MODE_MIN_IN: begin
								found <= seen_q;
								if (seen_q) begin
									min_source <= bsrc_q[ewt_pkg::FW-1:0];
									min_weight <= best_q;
								end else begin
									status <= ewt_pkg::STAT_NONE;
								end
							end
							default: ;
						endcase
					end
					out_valid <= 1'b1;
					state_q   <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

### sv/ewt_checker.sv
// Port-level checks of the weighted edge table, bound to the top level.
// Depends on ewt_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ewt_checker #(
	parameter int EDGE_SLOTS = 256
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_stall,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [1:0]                      status,
	input logic                            found,
	input logic [3:0]                      min_source,
	input logic signed [31:0]              min_weight,
	input logic [$clog2(EDGE_SLOTS+1)-1:0] edge_total
);
	`EWT_ASSERT_SAME(a_one_in_work, out_valid, in_stall)
	`EWT_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, in_stall && !out_valid)
	`EWT_ASSERT_SAME(a_found_ok, out_valid && found, status == ewt_pkg::STAT_OK)
	`EWT_ASSERT_SAME(a_min_clear, out_valid && !found, min_weight == 0 && min_source == 0)
	`EWT_ASSERT_SAME(a_total_range, out_valid, edge_total <= EDGE_SLOTS)
endmodule

bind weighted_edge_table_core ewt_checker #(.EDGE_SLOTS(EDGE_SLOTS)) u_ewt_checker (.*);
